/* rtl/sfrx_pkg.sv */
// ----------------------------------------------------------------------------
// sfrx_pkg
// shared constants and types for the serial frame receiver with xor check
// ----------------------------------------------------------------------------
package sfrx_pkg;

   localparam int RING_DEPTH = 1024;
   localparam int POS_W      = $clog2(RING_DEPTH);

   localparam int BYTE_W     = 8;
   localparam int FPOS_W     = 10;
   localparam int LEN_W      = 16;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [0:0] REG_HEADER_FIRST  = 1'b0;
   localparam logic [0:0] REG_HEADER_SECOND = 1'b1;

   localparam logic [BYTE_W-1:0] HEADER_FIRST_RST  = 8'd170;
   localparam logic [BYTE_W-1:0] HEADER_SECOND_RST = 8'd117;

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_HEAD1 = 8'b0000_0010,
      ST_HEAD2 = 8'b0000_0100,
      ST_CMD   = 8'b0000_1000,
      ST_LENHI = 8'b0001_0000,
      ST_LENLO = 8'b0010_0000,
      ST_DATA  = 8'b0100_0000,
      ST_CHECK = 8'b1000_0000
   } parse_state_type;

   typedef logic [POS_W-1:0] pos_type;

endpackage

/* rtl/sfrx_if.sv */
// ----------------------------------------------------------------------------
// sfrx_req_if / sfrx_rsp_if
// valid/ready channels for received bytes and per-byte frame results
// ----------------------------------------------------------------------------
interface sfrx_req_if;
   logic                       valid;
   logic                       ready;
   logic [sfrx_pkg::BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfrx_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [sfrx_pkg::FPOS_W-1:0] byte_pos;
   logic                        frame_done;
   logic [sfrx_pkg::FPOS_W-1:0] frame_start;
   logic [sfrx_pkg::FPOS_W-1:0] frame_end;
   logic [sfrx_pkg::BYTE_W-1:0] command;
   logic [sfrx_pkg::LEN_W-1:0]  data_length;
   logic                        checksum_ok;

   modport source (output valid, output byte_pos, output frame_done, output frame_start,
                   output frame_end, output command, output data_length,
                   output checksum_ok, input ready);
   modport sink   (input valid, input byte_pos, input frame_done, input frame_start,
                   input frame_end, input command, input data_length,
                   input checksum_ok, output ready);
endinterface

/* rtl/serial_frame_receiver_xor_check.sv */
// ----------------------------------------------------------------------------
// serial_frame_receiver_xor_check
// tags each received byte with its ring position and parses header, command,
// length, reserved, data and xor checksum fields of incoming frames
// ----------------------------------------------------------------------------
// each accepted byte's result is registered in the output register
// throughput: 1 byte per cycle; the parse state and output register update
//   in the same cycle, input ready whenever the output register is free or
//   being drained
// reset: synchronous active high; parser idle, ring position zero, headers
//   back to 170 and 117, no result pending
module serial_frame_receiver_xor_check (
   input  logic                            clock,
   input  logic                            reset,
   sfrx_req_if.sink                        req_chan,
   sfrx_rsp_if.source                      rsp_chan,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [sfrx_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [sfrx_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [sfrx_pkg::CSR_DATA_W-1:0] prdata,
   output logic                            pready
);

   logic [sfrx_pkg::BYTE_W-1:0] header_first_ff, header_second_ff;
   logic                        csr_wr;

   sfrx_pkg::parse_state_type   state_ff, state_in;
   sfrx_pkg::pos_type           wpos_ff, wpos_in;
   sfrx_pkg::pos_type           spos_ff, spos_in;
   logic [sfrx_pkg::LEN_W-1:0]  len_ff, len_in;
   logic [sfrx_pkg::LEN_W-1:0]  cnt_ff, cnt_in;
   logic [sfrx_pkg::LEN_W-1:0]  cnt_inc;
   logic [sfrx_pkg::BYTE_W-1:0] cmd_ff, cmd_in;
   logic [sfrx_pkg::BYTE_W-1:0] xor_ff, xor_in;

   logic                        accept;
   logic [sfrx_pkg::BYTE_W-1:0] b;

   logic                        done_in;
   logic [sfrx_pkg::FPOS_W-1:0] fstart_in, fend_in;
   logic [sfrx_pkg::BYTE_W-1:0] ocmd_in;
   logic [sfrx_pkg::LEN_W-1:0]  olen_in;
   logic                        ok_in;

   logic                        rsp_valid_ff;
   logic [sfrx_pkg::FPOS_W-1:0] byte_pos_ff, fstart_ff, fend_ff;
   logic                        done_ff, ok_ff;
   logic [sfrx_pkg::BYTE_W-1:0] ocmd_ff;
   logic [sfrx_pkg::LEN_W-1:0]  olen_ff;

   // csr port
   assign pready = 1'b1;
   assign csr_wr = psel & penable & pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         header_first_ff  <= sfrx_pkg::HEADER_FIRST_RST;
         header_second_ff <= sfrx_pkg::HEADER_SECOND_RST;
      end else if (csr_wr) begin
         if (paddr[2] == sfrx_pkg::REG_HEADER_FIRST) begin
            header_first_ff <= pwdata[sfrx_pkg::BYTE_W-1:0];
         end else begin
            header_second_ff <= pwdata[sfrx_pkg::BYTE_W-1:0];
         end
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[2] == sfrx_pkg::REG_HEADER_FIRST) begin
         prdata[sfrx_pkg::BYTE_W-1:0] = header_first_ff;
      end else begin
         prdata[sfrx_pkg::BYTE_W-1:0] = header_second_ff;
      end
   end

   // handshake
   assign req_chan.ready = ~rsp_valid_ff | rsp_chan.ready;
   assign accept         = req_chan.valid & req_chan.ready;
   assign b              = req_chan.rx_byte;
   assign cnt_inc        = cnt_ff + 1'b1;

   // frame parser
   always_comb begin
      state_in  = state_ff;
      spos_in   = spos_ff;
      len_in    = len_ff;
      cnt_in    = cnt_ff;
      cmd_in    = cmd_ff;
      xor_in    = xor_ff;
      done_in   = 1'b0;
      fstart_in = '0;
      fend_in   = '0;
      ocmd_in   = '0;
      olen_in   = '0;
      ok_in     = 1'b0;

      if (wpos_ff == sfrx_pkg::pos_type'(sfrx_pkg::RING_DEPTH - 1)) begin
         wpos_in = '0;
      end else begin
         wpos_in = wpos_ff + 1'b1;
      end

      case (state_ff)
         sfrx_pkg::ST_HEAD1: begin
            if (b == header_second_ff) begin
               state_in = sfrx_pkg::ST_HEAD2;
               xor_in   = xor_ff ^ b;
            end else begin
               state_in = sfrx_pkg::ST_IDLE;
            end
         end
         sfrx_pkg::ST_HEAD2: begin
            cmd_in   = b;
            xor_in   = xor_ff ^ b;
            state_in = sfrx_pkg::ST_CMD;
         end
         sfrx_pkg::ST_CMD: begin
            len_in   = {b, 8'h00};
            xor_in   = xor_ff ^ b;
            state_in = sfrx_pkg::ST_LENHI;
         end
         sfrx_pkg::ST_LENHI: begin
            len_in   = len_ff | {8'h00, b};
            xor_in   = xor_ff ^ b;
            state_in = sfrx_pkg::ST_LENLO;
         end
         sfrx_pkg::ST_LENLO: begin
            xor_in   = xor_ff ^ b;
            cnt_in   = '0;
            state_in = (len_ff == '0) ? sfrx_pkg::ST_CHECK : sfrx_pkg::ST_DATA;
         end
         sfrx_pkg::ST_DATA: begin
            xor_in = xor_ff ^ b;
            cnt_in = cnt_inc;
            if (cnt_inc >= len_ff) begin
               state_in = sfrx_pkg::ST_CHECK;
            end
         end
         sfrx_pkg::ST_CHECK: begin
            done_in   = 1'b1;
            fstart_in = sfrx_pkg::FPOS_W'(spos_ff);
            fend_in   = sfrx_pkg::FPOS_W'(wpos_ff);
            ocmd_in   = cmd_ff;
            olen_in   = len_ff;
            ok_in     = (xor_ff == b);
            state_in  = sfrx_pkg::ST_IDLE;
         end
         default: begin
            state_in = sfrx_pkg::ST_IDLE;
            if (b == header_first_ff) begin
               state_in = sfrx_pkg::ST_HEAD1;
               spos_in  = wpos_ff;
               xor_in   = b;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sfrx_pkg::ST_IDLE;
         wpos_ff  <= '0;
         spos_ff  <= '0;
         len_ff   <= '0;
         cnt_ff   <= '0;
         cmd_ff   <= '0;
         xor_ff   <= '0;
      end else if (accept) begin
         state_ff <= state_in;
         wpos_ff  <= wpos_in;
         spos_ff  <= spos_in;
         len_ff   <= len_in;
         cnt_ff   <= cnt_in;
         cmd_ff   <= cmd_in;
         xor_ff   <= xor_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         byte_pos_ff <= sfrx_pkg::FPOS_W'(wpos_ff);
         done_ff     <= done_in;
         fstart_ff   <= fstart_in;
         fend_ff     <= fend_in;
         ocmd_ff     <= ocmd_in;
         olen_ff     <= olen_in;
         ok_ff       <= ok_in;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.byte_pos    = byte_pos_ff;
   assign rsp_chan.frame_done  = done_ff;
   assign rsp_chan.frame_start = fstart_ff;
   assign rsp_chan.frame_end   = fend_ff;
   assign rsp_chan.command     = ocmd_ff;
   assign rsp_chan.data_length = olen_ff;
   assign rsp_chan.checksum_ok = ok_ff;

endmodule

/* rtl/sfrx_checker.sv */
// ----------------------------------------------------------------------------
// sfrx_checker
// port-level checks on the serial frame receiver result channel
// ----------------------------------------------------------------------------
module sfrx_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [sfrx_pkg::FPOS_W-1:0] byte_pos,
   input logic                        frame_done,
   input logic [sfrx_pkg::FPOS_W-1:0] frame_start,
   input logic [sfrx_pkg::FPOS_W-1:0] frame_end,
   input logic [sfrx_pkg::BYTE_W-1:0] command,
   input logic [sfrx_pkg::LEN_W-1:0]  data_length,
   input logic                        checksum_ok
);

   // stalled transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(byte_pos) && $stable(frame_done))
      else $error("result changed while stalled");

   // accepted byte shows up next cycle
   a_one_cycle: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted byte gave no result");

   // non-final bytes carry zero frame fields
   a_idle_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !frame_done |-> frame_start == '0 && frame_end == '0 &&
         command == '0 && data_length == '0 && !checksum_ok)
      else $error("frame fields set without frame end");

   // frame ends on the checksum byte itself
   a_end_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && frame_done |-> frame_end == byte_pos)
      else $error("frame end differs from byte position");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result pending after reset");

endmodule

bind serial_frame_receiver_xor_check sfrx_checker u_sfrx_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .byte_pos    (rsp_chan.byte_pos),
   .frame_done  (rsp_chan.frame_done),
   .frame_start (rsp_chan.frame_start),
   .frame_end   (rsp_chan.frame_end),
   .command     (rsp_chan.command),
   .data_length (rsp_chan.data_length),
   .checksum_ok (rsp_chan.checksum_ok)
);

/* tb/frame_result_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// frame_result_checker
// follows accepted bytes and header register writes, predicts the ring
// position and frame report for every byte, and compares each result
// transaction in order against the oldest prediction
// ----------------------------------------------------------------------------
module frame_result_checker
   import sfrx_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   sfrx_req_if                   req_mon,
   sfrx_rsp_if                   rsp_mon,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic                  pready,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output int                    mismatches,
   output int                    pending
);

   typedef struct packed {
      logic [FPOS_W-1:0] byte_pos;
      logic              frame_done;
      logic [FPOS_W-1:0] frame_start;
      logic [FPOS_W-1:0] frame_end;
      logic [BYTE_W-1:0] command;
      logic [LEN_W-1:0]  data_length;
      logic              checksum_ok;
   } byte_report_type;

   byte_report_type   expected_reports[$];

   logic [BYTE_W-1:0] hdr_first;
   logic [BYTE_W-1:0] hdr_second;
   parse_state_type   parse_st;
   pos_type           wr_pos;
   pos_type           frame_base;
   logic [LEN_W-1:0]  len_hdr;
   logic [LEN_W-1:0]  data_seen;
   logic [BYTE_W-1:0] cmd_hdr;
   logic [BYTE_W-1:0] xor_acc;

   function automatic byte_report_type parse_byte(input logic [BYTE_W-1:0] b);
      byte_report_type r;
      r = '0;
      r.byte_pos = wr_pos;
      case (parse_st)
         ST_HEAD1: begin
            if (b == hdr_second) begin
               parse_st = ST_HEAD2;
               xor_acc ^= b;
            end else begin
               parse_st = ST_IDLE;
            end
         end
         ST_HEAD2: begin
            cmd_hdr = b;
            xor_acc ^= b;
            parse_st = ST_CMD;
         end
         ST_CMD: begin
            len_hdr = {b, 8'h00};
            xor_acc ^= b;
            parse_st = ST_LENHI;
         end
         ST_LENHI: begin
            len_hdr[7:0] = b;
            xor_acc ^= b;
            parse_st = ST_LENLO;
         end
         ST_LENLO: begin
            xor_acc ^= b;
            data_seen = '0;
            parse_st = (len_hdr == '0) ? ST_CHECK : ST_DATA;
         end
         ST_DATA: begin
            xor_acc ^= b;
            data_seen = data_seen + 1'b1;
            if (data_seen >= len_hdr) begin
               parse_st = ST_CHECK;
            end
         end
         ST_CHECK: begin
            r.frame_done  = 1'b1;
            r.frame_start = frame_base;
            r.frame_end   = wr_pos;
            r.command     = cmd_hdr;
            r.data_length = len_hdr;
            r.checksum_ok = (xor_acc == b);
            parse_st = ST_IDLE;
         end
         default: begin
            parse_st = ST_IDLE;
            if (b == hdr_first) begin
               parse_st = ST_HEAD1;
               frame_base = wr_pos;
               xor_acc = b;
            end
         end
      endcase
      wr_pos = (wr_pos == pos_type'(RING_DEPTH - 1)) ? '0 : wr_pos + 1'b1;
      return r;
   endfunction

   task automatic report(input string field, input logic [LEN_W-1:0] got,
                         input logic [LEN_W-1:0] want);
      mismatches++;
      $display("mismatch at %0t: %s got %0h expected %0h", $realtime, field, got, want);
   endtask

   task automatic compare_report(input byte_report_type want);
      if (rsp_mon.byte_pos !== want.byte_pos)
         report("byte_pos", LEN_W'(rsp_mon.byte_pos), LEN_W'(want.byte_pos));
      if (rsp_mon.frame_done !== want.frame_done)
         report("frame_done", LEN_W'(rsp_mon.frame_done), LEN_W'(want.frame_done));
      if (rsp_mon.frame_start !== want.frame_start)
         report("frame_start", LEN_W'(rsp_mon.frame_start), LEN_W'(want.frame_start));
      if (rsp_mon.frame_end !== want.frame_end)
         report("frame_end", LEN_W'(rsp_mon.frame_end), LEN_W'(want.frame_end));
      if (rsp_mon.command !== want.command)
         report("command", LEN_W'(rsp_mon.command), LEN_W'(want.command));
      if (rsp_mon.data_length !== want.data_length)
         report("data_length", rsp_mon.data_length, want.data_length);
      if (rsp_mon.checksum_ok !== want.checksum_ok)
         report("checksum_ok", LEN_W'(rsp_mon.checksum_ok), LEN_W'(want.checksum_ok));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         hdr_first  = HEADER_FIRST_RST;
         hdr_second = HEADER_SECOND_RST;
         parse_st   = ST_IDLE;
         wr_pos     = '0;
         frame_base = '0;
         len_hdr    = '0;
         data_seen  = '0;
         cmd_hdr    = '0;
         xor_acc    = '0;
         expected_reports.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_reports.size() == 0) begin
               report("transaction with nothing expected, byte_pos",
                      LEN_W'(rsp_mon.byte_pos), '0);
            end else begin
               compare_report(expected_reports.pop_front());
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            expected_reports.push_back(parse_byte(req_mon.rx_byte));
         end
         if (psel && penable && pwrite && pready) begin
            if (paddr[2] == REG_HEADER_FIRST) begin
               hdr_first = pwdata[BYTE_W-1:0];
            end else begin
               hdr_second = pwdata[BYTE_W-1:0];
            end
         end
      end
      pending <= expected_reports.size();
   end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// drives received bytes into the serial frame receiver: a short directed
// run, one long frame, then mostly well-formed frames with random
// content mixed with noise, header mismatches, truncated frames and bad
// checksums under several header settings, with random idling on both sides
// ----------------------------------------------------------------------------
module testbench;
   import sfrx_pkg::*;

   localparam int CYCLE_LIMIT = 3_000_000;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   int                    mismatches;
   int                    pending;
   int                    items = 0;
   int                    cycles = 0;
   bit                    quiet = 1'b0;
   int                    send_gap_pct = 20;
   logic [BYTE_W-1:0]     cur_first = HEADER_FIRST_RST;
   logic [BYTE_W-1:0]     cur_second = HEADER_SECOND_RST;

   sfrx_req_if req_if ();
   sfrx_rsp_if rsp_if ();

   serial_frame_receiver_xor_check u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   frame_result_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_if),
      .rsp_mon    (rsp_if),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .pready     (pready),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .mismatches (mismatches),
      .pending    (pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   task automatic send_byte(input logic [BYTE_W-1:0] b);
      if (!quiet && $urandom_range(0, 99) < send_gap_pct) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.rx_byte <= b;
      do @(posedge clock); while (!req_if.ready);
      items++;
   endtask

   task automatic send_summed(input logic [BYTE_W-1:0] b, inout logic [BYTE_W-1:0] acc);
      acc ^= b;
      send_byte(b);
   endtask

   task automatic send_noise_byte();
      logic [BYTE_W-1:0] b;
      do b = BYTE_W'($urandom()); while (b == cur_first);
      send_byte(b);
   endtask

   // truncated frames stop inside the data and send no checksum
   task automatic send_frame(input logic [BYTE_W-1:0] cmd, input logic [LEN_W-1:0] len,
                             input bit good_sum, input bit truncate);
      logic [BYTE_W-1:0] acc;
      int                count;
      acc = '0;
      count = (truncate && len != 0) ? $urandom_range(0, len - 1) : len;
      send_summed(cur_first, acc);
      send_summed(cur_second, acc);
      send_summed(cmd, acc);
      send_summed(len[15:8], acc);
      send_summed(len[7:0], acc);
      send_summed(BYTE_W'($urandom()), acc);
      for (int i = 0; i < count; i++) begin
         send_summed(BYTE_W'($urandom()), acc);
      end
      if (!truncate) begin
         send_byte(good_sum ? acc : acc ^ BYTE_W'($urandom_range(1, 255)));
      end
   endtask

   task automatic pause_until_drained();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (2) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr, input logic [BYTE_W-1:0] value);
      logic [CSR_DATA_W-1:0] word;
      word = $urandom();
      word[BYTE_W-1:0] = value;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= word;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic set_headers(input logic [BYTE_W-1:0] first, input logic [BYTE_W-1:0] second);
      pause_until_drained();
      csr_write({REG_HEADER_FIRST, 2'b00}, first);
      csr_write({REG_HEADER_SECOND, 2'b00}, second);
      cur_first  = first;
      cur_second = second;
   endtask

   function automatic logic [LEN_W-1:0] pick_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return LEN_W'($urandom_range(0, 16));
      if (r < 95) return LEN_W'($urandom_range(17, 80));
      return LEN_W'($urandom_range(200, 700));
   endfunction

   task automatic random_phase(input int target);
      int                r;
      logic [BYTE_W-1:0] b;
      while (items < target) begin
         send_gap_pct = ($urandom_range(0, 2) == 0) ? 0 : 20;
         if ($urandom_range(0, 99) < 3) begin
            pause_until_drained();
         end
         r = $urandom_range(0, 99);
         if (r < 70) begin
            send_frame(BYTE_W'($urandom()), pick_length(), $urandom_range(0, 4) != 0, 1'b0);
         end else if (r < 78) begin
            repeat ($urandom_range(1, 6)) send_noise_byte();
         end else if (r < 86) begin
            // second header byte wrong, possibly equal to the first header
            send_byte(cur_first);
            do b = ($urandom_range(0, 3) == 0) ? cur_first : BYTE_W'($urandom());
            while (b == cur_second);
            send_byte(b);
         end else if (r < 93) begin
            send_frame(BYTE_W'($urandom()), LEN_W'($urandom_range(1, 8)), 1'b1, 1'b1);
         end else begin
            send_frame(BYTE_W'($urandom()), pick_length(), 1'b0, 1'b0);
         end
      end
   endtask

   initial begin
      reset          <= 1'b1;
      req_if.valid   <= 1'b0;
      req_if.rx_byte <= '0;
      psel           <= 1'b0;
      penable        <= 1'b0;
      pwrite         <= 1'b0;
      paddr          <= '0;
      pwdata         <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // idle noise, second header mismatch not retried as first header
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(HEADER_FIRST_RST);
      send_byte(HEADER_FIRST_RST);
      send_byte(HEADER_SECOND_RST);
      send_frame(8'h00, 16'h0000, 1'b1, 1'b0);
      send_frame(8'hFF, 16'h0001, 1'b0, 1'b0);

      // long frame, length high byte in use
      send_frame(BYTE_W'($urandom()), 16'h0123, 1'b1, 1'b0);

      random_phase(items + 250);
      set_headers(8'h00, 8'hFF);
      random_phase(items + 200);
      set_headers(8'hFF, 8'h00);
      random_phase(items + 200);
      set_headers(8'h3C, 8'h3C);
      random_phase(items + 200);
      set_headers(BYTE_W'($urandom()), BYTE_W'($urandom()));
      random_phase(items + 150);
      set_headers(HEADER_FIRST_RST, HEADER_SECOND_RST);
      quiet = 1'b1;
      random_phase(items + 100);

      pause_until_drained();
      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      rsp_if.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         repeat ($urandom_range(1, 30)) @(posedge clock);
      end
   end

endmodule

/* sim.f */
rtl/sfrx_pkg.sv
rtl/sfrx_if.sv
rtl/serial_frame_receiver_xor_check.sv
rtl/sfrx_checker.sv
tb/frame_result_checker.sv
tb/testbench.sv
